FILE: rtl/pvs_pkg.sv
`default_nettype none

package pvs_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_COEFFS = 7;
    localparam int CFG_ADDR_W = 5;

    typedef logic signed [WORD_W-1:0]   word_t;
    typedef logic signed [2*WORD_W-1:0] wide_t;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    // Register map, one 32-bit word per register.
    typedef enum logic [2:0] {
        REG_DEGREE  = 3'd0,
        REG_COEFF_0 = 3'd1,
        REG_COEFF_1 = 3'd2,
        REG_COEFF_2 = 3'd3,
        REG_COEFF_3 = 3'd4,
        REG_COEFF_4 = 3'd5,
        REG_COEFF_5 = 3'd6,
        REG_COEFF_6 = 3'd7
    } reg_idx_t;

    // Word between Horner steps.
    typedef struct packed {
        word_t x;
        word_t r;
        word_t s;
        logic  ovf;
    } beat_t;

    // Word after the multiply half of a Horner step.
    typedef struct packed {
        word_t x;
        word_t r;
        word_t s;
        wide_t pr;
        wide_t ps;
        word_t term;
        logic  tovf;
        logic  ovf;
    } prod_t;

    typedef struct packed {
        word_t val;
        logic  ovf;
    } sat_t;

    // Clamp a wide signed value to the 32-bit range and flag the clamp.
    function automatic sat_t sat_word(input wide_t v);
        sat_t res;
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[2*WORD_W-1:WORD_W-1];
        hi_zeros = ~|v[2*WORD_W-1:WORD_W-1];
        res.ovf  = !(hi_ones || hi_zeros);
        if (res.ovf)
        begin
            res.val = v[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            res.val = v[WORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/polynomial_value_and_slope.sv
`default_nettype none

// Polynomial value and slope. For each point word x the block returns p(x)
// and p'(x) of a polynomial of degree 0..MAX_DEGREE, both by Horner's rule,
// in signed fixed point with FRAC_BITS fraction bits (Q16.16 by default).
// Each product is floored (arithmetic shift right by FRAC_BITS) and every
// intermediate is clamped to 32 bits; overflow is set for a word when any
// clamp fired. Degree above MAX_DEGREE is treated as MAX_DEGREE, and degree
// zero gives a slope of zero. Registers (APB, 4-byte stride): 0 degree,
// 1..7 coeff_0..coeff_6. Write them only while no word is in flight.
// Throughput is one word per clock while the output is not stalled. A point
// taken passes one entry stage on its way to out_valid, then each Horner step
// is a multiply stage (two 32x32 multipliers for value and slope) followed by
// a shift, clamp and add stage. A stalled output holds only the stages behind
// it that are full; empty stages keep taking words.
module polynomial_value_and_slope #(
    parameter int MAX_DEGREE = 6,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pvs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [pvs_pkg::WORD_W-1:0]       pwdata,
    output logic      [pvs_pkg::WORD_W-1:0]       prdata,
    output logic                                  pready,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire pvs_pkg::word_t                   point,
    // output channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output pvs_pkg::word_t                        value,
    output pvs_pkg::word_t                        slope,
    output logic                                  overflow
);

    import pvs_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [2:0] degree_reg;
    logic [2:0] degree_next;
    word_t      coeff_reg  [NUM_COEFFS];
    word_t      coeff_next [NUM_COEFFS];
    reg_idx_t   cfg_idx;
    logic       cfg_wr;
    logic [2:0] deg_eff;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        degree_next = degree_reg;
        if (cfg_wr && cfg_idx == REG_DEGREE)
        begin
            degree_next = pwdata[2:0];
        end
        for (int j = 0; j < NUM_COEFFS; j++)
        begin
            coeff_next[j] = coeff_reg[j];
            if (cfg_wr && cfg_idx == reg_idx_t'(3'(int'(REG_COEFF_0) + j)))
            begin
                coeff_next[j] = pwdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            for (int j = 0; j < NUM_COEFFS; j++)
            begin
                coeff_reg[j] <= '0;
            end
        end
        else
        begin
            degree_reg <= degree_next;
            for (int j = 0; j < NUM_COEFFS; j++)
            begin
                coeff_reg[j] <= coeff_next[j];
            end
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_DEGREE:  prdata = {{(WORD_W-3){1'b0}}, degree_reg};
            REG_COEFF_0: prdata = coeff_reg[0];
            REG_COEFF_1: prdata = coeff_reg[1];
            REG_COEFF_2: prdata = coeff_reg[2];
            REG_COEFF_3: prdata = coeff_reg[3];
            REG_COEFF_4: prdata = coeff_reg[4];
            REG_COEFF_5: prdata = coeff_reg[5];
            REG_COEFF_6: prdata = coeff_reg[6];
            default:     prdata = '0;
        endcase
    end

    // Degree in use: clamp to what the pipeline has steps for.
    assign deg_eff = (degree_reg > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : degree_reg;

    // ---------------------------------------------------------------
    // Pipeline: P0, M0, P1, M1, ... M(D-1), P(D). P(D) is the output word.
    // Step k works on coefficient index MAX_DEGREE-1-k, so all degrees end
    // aligned at P(D); steps at or above the degree pass the word through.
    // ---------------------------------------------------------------
    beat_t pipe_reg  [MAX_DEGREE+1];
    beat_t pipe_next [MAX_DEGREE+1];
    prod_t mid_reg   [MAX_DEGREE];
    prod_t mid_next  [MAX_DEGREE];

    logic [MAX_DEGREE:0]   pipe_vld_reg;
    logic [MAX_DEGREE:0]   pipe_vld_next;
    logic [MAX_DEGREE-1:0] mid_vld_reg;
    logic [MAX_DEGREE-1:0] mid_vld_next;
    logic [MAX_DEGREE:0]   pipe_en;
    logic [MAX_DEGREE-1:0] mid_en;

    // A stage loads when it is empty or its word moves on this cycle.
    always_comb
    begin
        pipe_en[MAX_DEGREE] = !pipe_vld_reg[MAX_DEGREE] || !out_stall;
        for (int k = MAX_DEGREE - 1; k >= 0; k--)
        begin
            mid_en[k]  = !mid_vld_reg[k] || pipe_en[k+1];
            pipe_en[k] = !pipe_vld_reg[k] || mid_en[k];
        end
    end

    assign in_stall = !pipe_en[0];

    always_comb
    begin
        pipe_vld_next[0] = pipe_en[0] ? in_valid : pipe_vld_reg[0];
        for (int k = 0; k < MAX_DEGREE; k++)
        begin
            mid_vld_next[k]    = mid_en[k] ? pipe_vld_reg[k] : mid_vld_reg[k];
            pipe_vld_next[k+1] = pipe_en[k+1] ? mid_vld_reg[k] : pipe_vld_reg[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= '0;
            mid_vld_reg  <= '0;
        end
        else
        begin
            pipe_vld_reg <= pipe_vld_next;
            mid_vld_reg  <= mid_vld_next;
        end
    end

    // Entry: load the leading coefficient and the leading slope term n*c[n].
    wide_t lead_prod;
    sat_t  lead_sat;

    always_comb
    begin
        lead_prod    = wide_t'(coeff_reg[deg_eff]) * wide_t'(signed'({1'b0, deg_eff}));
        lead_sat     = sat_word(lead_prod);
        pipe_next[0] = '{x: point, r: coeff_reg[deg_eff], s: lead_sat.val,
                         ovf: lead_sat.ovf};
    end

    for (genvar k = 0; k < MAX_DEGREE; k++)
    begin : g_step
        localparam int IDX = MAX_DEGREE - 1 - k;

        sat_t term_sat;
        sat_t mr_sat;
        sat_t ar_sat;
        sat_t ms_sat;
        sat_t as_sat;
        logic act_r;
        logic act_s;

        // Multiply half: both products, plus the slope term IDX*c[IDX].
        always_comb
        begin
            term_sat         = sat_word(wide_t'(coeff_reg[IDX]) * wide_t'(IDX));
            mid_next[k].x    = pipe_reg[k].x;
            mid_next[k].r    = pipe_reg[k].r;
            mid_next[k].s    = pipe_reg[k].s;
            mid_next[k].ovf  = pipe_reg[k].ovf;
            mid_next[k].pr   = wide_t'(pipe_reg[k].r) * wide_t'(pipe_reg[k].x);
            mid_next[k].ps   = wide_t'(pipe_reg[k].s) * wide_t'(pipe_reg[k].x);
            mid_next[k].term = term_sat.val;
            mid_next[k].tovf = term_sat.ovf;
        end

        // Shift, clamp and add half. Value steps run for IDX below the
        // degree; slope steps skip the constant term.
        always_comb
        begin
            act_r  = 3'(IDX) < deg_eff;
            act_s  = act_r && (IDX != 0);
            mr_sat = sat_word(mid_reg[k].pr >>> FRAC_BITS);
            ar_sat = sat_word(wide_t'(mr_sat.val) + wide_t'(coeff_reg[IDX]));
            ms_sat = sat_word(mid_reg[k].ps >>> FRAC_BITS);
            as_sat = sat_word(wide_t'(ms_sat.val) + wide_t'(mid_reg[k].term));

            pipe_next[k+1].x   = mid_reg[k].x;
            pipe_next[k+1].r   = act_r ? ar_sat.val : mid_reg[k].r;
            pipe_next[k+1].s   = act_s ? as_sat.val : mid_reg[k].s;
            pipe_next[k+1].ovf = mid_reg[k].ovf
                               | (act_r & (mr_sat.ovf | ar_sat.ovf))
                               | (act_s & (ms_sat.ovf | as_sat.ovf | mid_reg[k].tovf));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= MAX_DEGREE; k++)
        begin
            if (pipe_en[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        for (int k = 0; k < MAX_DEGREE; k++)
        begin
            if (mid_en[k])
            begin
                mid_reg[k] <= mid_next[k];
            end
        end
    end

    // Output word sits in the last stage.
    assign out_valid = pipe_vld_reg[MAX_DEGREE];
    assign value     = pipe_reg[MAX_DEGREE].r;
    assign slope     = pipe_reg[MAX_DEGREE].s;
    assign overflow  = pipe_reg[MAX_DEGREE].ovf;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // A taken point always lands in the entry stage.
    a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> pipe_vld_reg[0])
        else $error("accepted point did not reach the entry stage");

    // Back-pressure reaches the input only when every stage is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&pipe_vld_reg) && (&mid_vld_reg) && out_stall))
        else $error("input stalled while the pipeline has a bubble");

    // A word in the output stage under stall stays there.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_vld_reg[MAX_DEGREE] && out_stall) |=> pipe_vld_reg[MAX_DEGREE])
        else $error("output stage lost a stalled word");

endmodule

`default_nettype wire

FILE: tb/sv/pvs_result_check.sv
module pvs_result_check #(
    parameter int MAX_DEGREE = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pvs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pvs_pkg::WORD_W-1:0]         pwdata,
    input  logic                               pready,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  pvs_pkg::word_t                     point,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  pvs_pkg::word_t                     value,
    input  pvs_pkg::word_t                     slope,
    input  logic                               overflow,
    output int                                 mismatch_count,
    output int                                 pending
);
    import pvs_pkg::*;

    typedef struct packed {
        word_t value;
        word_t slope;
        logic  overflow;
    } poly_result_t;

    logic [2:0]   degree_cfg;
    word_t        coeff_cfg [NUM_COEFFS];
    poly_result_t expected_results [$];
    int           miss_total;

    // Clamp to the signed 32-bit range and raise the flag on a clamp.
    function automatic longint clamp32(input longint v, inout bit flag);
        if (v > longint'(WORD_MAX))
        begin
            flag = 1'b1;
            return longint'(WORD_MAX);
        end
        if (v < longint'(WORD_MIN))
        begin
            flag = 1'b1;
            return longint'(WORD_MIN);
        end
        return v;
    endfunction

    // Value and slope of the programmed polynomial at x, Horner's rule.
    function automatic poly_result_t eval_value_slope(input word_t x_w);
        longint       x;
        longint       r;
        longint       s;
        longint       term;
        bit           flag;
        int           n;
        int           i;
        poly_result_t res;
        x    = longint'(x_w);
        n    = (int'(degree_cfg) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_cfg);
        flag = 1'b0;
        r    = longint'(coeff_cfg[n]);
        for (i = n - 1; i >= 0; i--)
        begin
            r = clamp32((r * x) >>> FRAC_BITS, flag);
            r = clamp32(r + longint'(coeff_cfg[i]), flag);
        end
        if (n == 0)
        begin
            s = 0;
        end
        else
        begin
            s = clamp32(longint'(coeff_cfg[n]) * n, flag);
            for (i = n - 1; i > 0; i--)
            begin
                term = clamp32(longint'(coeff_cfg[i]) * i, flag);
                s    = clamp32((s * x) >>> FRAC_BITS, flag);
                s    = clamp32(s + term, flag);
            end
        end
        res.value    = word_t'(r);
        res.slope    = word_t'(s);
        res.overflow = flag;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        poly_result_t want;
        reg_idx_t     idx;
        if (!rst_n)
        begin
            degree_cfg = '0;
            foreach (coeff_cfg[k])
                coeff_cfg[k] = '0;
            expected_results.delete();
            miss_total = 0;
            mismatch_count <= 0;
            pending <= 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                idx = reg_idx_t'(paddr[4:2]);
                if (idx == REG_DEGREE)
                    degree_cfg = pwdata[2:0];
                else
                    coeff_cfg[int'(idx) - int'(REG_COEFF_0)] = word_t'(pwdata);
            end
            // compare an accepted result with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    miss_total++;
                    if (miss_total <= 10)
                        $display("unexpected result: value %h slope %h overflow %b",
                                 value, slope, overflow);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.value !== value || want.slope !== slope ||
                        want.overflow !== overflow)
                    begin
                        miss_total++;
                        if (miss_total <= 10)
                            $display("result mismatch: expected value %h slope %h ovf %b,",
                                     want.value, want.slope, want.overflow,
                                     " got value %h slope %h ovf %b",
                                     value, slope, overflow);
                    end
                end
            end
            // predict for an accepted point
            if (in_valid && !in_stall)
                expected_results.push_back(eval_value_slope(point));
            mismatch_count <= miss_total;
            pending <= expected_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_polynomial_value_and_slope.sv
module tb_polynomial_value_and_slope;
    import pvs_pkg::*;

    localparam int MAX_DEGREE   = 6;
    localparam int FRAC_BITS    = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4 * MAX_DEGREE;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 64;
    localparam int PRESSURE_PH  = 5;
    // Most coefficients within +-4.0 and most points within +-2.0, so that
    // a degree-6 polynomial mostly stays unsaturated.
    localparam int COEFF_SPAN   = 32'h0004_0000;
    localparam int POINT_SPAN   = 32'h0002_0000;

    typedef enum int {
        PACE_FULL,
        PACE_SENDER_SLOW,
        PACE_RECEIVER_SLOW,
        PACE_BOTH
    } pace_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [WORD_W-1:0]       pwdata;
    logic [WORD_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    word_t                   point;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    word_t                   value;
    word_t                   slope;
    logic                    overflow;

    int                      mismatch_count;
    int                      pending;
    int                      idle_pct = 0;
    int                      stall_pct = 0;
    int                      cycle_count = 0;
    logic                    hold_start = 1'b0;
    logic                    hold_off = 1'b0;
    word_t                   coef_plan [NUM_COEFFS];

    always #10 clk = ~clk;

    polynomial_value_and_slope #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point     (point),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .slope     (slope),
        .overflow  (overflow)
    );

    pvs_result_check #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .point          (point),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .slope          (slope),
        .overflow       (overflow),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // Receiver: stall at random at the current rate; hold stall for the
    // whole hold-off stretch.
    always @(negedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end

    // Hold-off: once asked, keep the receiver stalled for a long stretch
    // so the pipeline fills and pushes back on the sender.
    initial
    begin
        wait (hold_start);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly a small signed fixed-point value within +-span, now and then
    // a full-range word or one of the two extremes.
    function automatic word_t rand_fixed(input int span);
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return WORD_MAX;
        if (pick == 1)
            return WORD_MIN;
        if (pick < 5)
            return word_t'($urandom());
        return word_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input reg_idx_t idx, input word_t data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Program degree and all seven coefficients from coef_plan.
    task automatic program_poly(input logic [2:0] deg);
        write_reg(REG_DEGREE, word_t'({29'd0, deg}));
        write_reg(REG_COEFF_0, coef_plan[0]);
        write_reg(REG_COEFF_1, coef_plan[1]);
        write_reg(REG_COEFF_2, coef_plan[2]);
        write_reg(REG_COEFF_3, coef_plan[3]);
        write_reg(REG_COEFF_4, coef_plan[4]);
        write_reg(REG_COEFF_5, coef_plan[5]);
        write_reg(REG_COEFF_6, coef_plan[6]);
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FULL:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            PACE_SENDER_SLOW:
            begin
                idle_pct  = 83;
                stall_pct = 0;
            end
            PACE_RECEIVER_SLOW:
            begin
                idle_pct  = 0;
                stall_pct = 83;
            end
            default:
            begin
                idle_pct  = 20;
                stall_pct = 20;
            end
        endcase
    endtask

    // Offer one point word and hold it until accepted. Valid stays high
    // into the next word unless an idle gap is drawn.
    task automatic send_point(input word_t x);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        point    <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid after a burst and wait until every result is back, so
    // the registers may be written.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    initial
    begin : stimulus
        word_t edge_points [8];
        word_t tame_points [5];
        int    p;
        int    k;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        point    = '0;
        rst_n    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_pace(PACE_FULL);

        // Degree zero: value is the constant term, slope zero, no flag,
        // whatever the higher coefficients hold.
        coef_plan[0] = WORD_MIN;
        for (k = 1; k < NUM_COEFFS; k++)
            coef_plan[k] = word_t'($urandom());
        program_poly(3'd0);
        send_point('0);
        send_point(WORD_MAX);
        send_point(word_t'($urandom()));
        drain();

        // Degree above the maximum clamps; extreme coefficients and points
        // drive saturation in both recurrences.
        coef_plan[0] = WORD_MAX;
        coef_plan[1] = WORD_MIN;
        coef_plan[2] = 32'sh0000_8000;
        coef_plan[3] = -32'sh0001_0000;
        coef_plan[4] = 32'sh0001_0000;
        coef_plan[5] = WORD_MIN;
        coef_plan[6] = WORD_MAX;
        program_poly(3'd7);
        edge_points = '{32'sh0000_0000, 32'sh0001_0000, -32'sh0001_0000, WORD_MAX,
                        WORD_MIN, -32'sh0000_0001, 32'sh0000_0001, 32'sh0000_8000};
        foreach (edge_points[k])
            send_point(edge_points[k]);
        drain();

        // Low degree with huge coefficients above it: those must be ignored.
        coef_plan[0] = 32'sh0001_8000;
        coef_plan[1] = -32'sh0002_0000;
        coef_plan[2] = 32'sh0000_4000;
        for (k = 3; k < NUM_COEFFS; k++)
            coef_plan[k] = WORD_MAX;
        program_poly(3'd2);
        tame_points = '{32'sh0001_0000, 32'sh0002_8000, -32'sh0000_8000,
                        32'sh0000_0003, -32'sh0000_0003};
        foreach (tame_points[k])
            send_point(tame_points[k]);
        drain();

        // Random phases: fresh polynomial each time, cycling through the
        // idle patterns; one phase parks the receiver to force backpressure.
        for (p = 0; p < PHASES; p++)
        begin
            for (k = 0; k < NUM_COEFFS; k++)
                coef_plan[k] = rand_fixed(COEFF_SPAN);
            if (p == 0)
                program_poly(3'd6);
            else
                program_poly(3'($urandom_range(0, 7)));
            if (p == PRESSURE_PH)
            begin
                set_pace(PACE_FULL);
                hold_start = 1'b1;
            end
            else
            begin
                set_pace(pace_t'(p % 4));
            end
            for (k = 0; k < PHASE_WORDS; k++)
                send_point(rand_fixed(POINT_SPAN));
            drain();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: polynomial_value_and_slope.f
rtl/pvs_pkg.sv
rtl/polynomial_value_and_slope.sv
tb/sv/pvs_result_check.sv
tb/sv/tb_polynomial_value_and_slope.sv
